[rtl/vrog_pkg.sv]
// vrog_pkg: shared types and constants of the voxel ray occlusion grid
// no dependencies; imported by voxel_ray_occlusion_grid and tb_top
`default_nettype none

package vrog_pkg;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 32;
  localparam int DIR_W      = 18;
  localparam int REACH_W    = 31;
  localparam int VS_W       = 31;
  localparam int MAXV_W     = 13;
  localparam int SMP_W      = 8;
  localparam int RATIO_W    = 17;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier and divider widths
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int DIV_N_W = 63;
  localparam int DIV_D_W = 18;
  localparam int DCNT_W  = 6;

  // walk times in q16.16, saturating at 2^48
  localparam int T_W    = 49;
  localparam int DIST_W = 47;
  localparam logic [T_W-1:0]    T_INF    = 49'd1 << 48;
  localparam logic [DIST_W-1:0] DIST_CAP = 47'd1 << 46;

  localparam logic [VS_W-1:0]   VS_RST   = 31'd6554;
  localparam logic [VS_W-1:0]   INV_RST  = 31'd655360;
  localparam logic [MAXV_W-1:0] MAXV_RST = 13'd4096;
  localparam logic [SMP_W-1:0]  SMP_RST  = 8'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_WALK   = 2'd2,
    CMD_RATIO  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOXEL_SIZE     = 3'd0,
    REG_INV_VOXEL_SIZE = 3'd1,
    REG_MAX_VOXELS     = 3'd2,
    REG_SAMPLE_STEPS   = 3'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CELL_MUL,
    S_CELL_WB,
    S_SET_MUL,
    S_SET_DIST,
    S_SET_TB,
    S_SET_DT,
    S_WALK,
    S_SCAN,
    S_POST,
    S_SMP_MUL,
    S_SMP_DLD,
    S_SMP_DIV,
    S_PT_MUL,
    S_PT_ADD,
    S_RAT_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/voxel_ray_occlusion_grid.sv]
// voxel_ray_occlusion_grid: occupied voxel key set with ray walk and sampled queries
// depends on vrog_pkg
`default_nettype none

// Usage
//   An item (command plus point/ray fields) is taken when start is high and busy
//   is low. busy stays high until the single result has been shown: out_valid
//   is high for exactly one cycle with all out_ fields; the receiver cannot stall.
//   Configuration writes (cfg_valid and cfg_ready, ready is always high) are to go in
//   only while idle (not enforced by the block); unknown indexes are ignored.
// Sequence (one item at a time, N = stored key count)
//   clear: goes straight to the result. insert: voxel cell per axis, then a scan of up to N keys.
//   walk: setup with up to six quotients (two per axis with a nonzero direction)
//   from a one bit per cycle divider, then a scan of up to N keys per voxel visited.
//   ratio: per sample a product, a quotient, the sample point and its cell, and
//   a scan of up to N keys, then a final quotient for the ratio. The key table
//   scan reads one entry per cycle over the single table read port.
// Reset
//   rst_n low clears the key count and loads the register defaults; the key
//   table itself is not cleared, only its first N entries are ever read.

module voxel_ray_occlusion_grid #(
  parameter int CAPACITY       = 4096,
  parameter int MAX_WALK_STEPS = 1024,
  parameter int KEY_AXIS_BITS  = 21
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [vrog_pkg::CMD_W-1:0]             in_command,
  input  logic signed [vrog_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [vrog_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [vrog_pkg::POS_W-1:0]      in_pos_z,
  input  logic signed [vrog_pkg::DIR_W-1:0]      in_dir_x,
  input  logic signed [vrog_pkg::DIR_W-1:0]      in_dir_y,
  input  logic signed [vrog_pkg::DIR_W-1:0]      in_dir_z,
  input  logic [vrog_pkg::REACH_W-1:0]           in_reach,
  output logic                                   out_valid,
  output logic                                   out_occluded,
  output logic [vrog_pkg::SMP_W-1:0]             out_hit_samples,
  output logic [vrog_pkg::RATIO_W-1:0]           out_ratio,
  output logic                                   out_inserted,
  output logic                                   out_full_res,
  output logic [vrog_pkg::CNT_W-1:0]             out_stored_count,
  output logic                                   out_truncated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vrog_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vrog_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import vrog_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int KEY_W = 3 * KEY_AXIS_BITS;
  localparam int SW    = $clog2(MAX_WALK_STEPS + 1);
  localparam int CAP_LIM = (CAPACITY < 8191) ? CAPACITY : 8191;
  localparam logic [CNT_W-1:0] CAP_LIM_C = CNT_W'(CAP_LIM);
  localparam logic [1:0] AX_LAST = 2'd2;

  typedef logic [AW-1:0] addr_t;

  state_t state_r, state_nxt;

  // configuration and key count
  logic [VS_W-1:0]   vs_r, inv_r;
  logic [MAXV_W-1:0] maxv_r;
  logic [SMP_W-1:0]  smp_r;
  logic [CNT_W-1:0]  key_count_r, limit;

  // item registers
  cmd_t                    cmd_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [POS_W-1:0] pt_r [3];
  logic signed [DIR_W-1:0] dir_r [3];
  logic [REACH_W-1:0]      reach_r;
  logic signed [POS_W-1:0] cell_r [3];
  logic [T_W-1:0]          tb_r [3];
  logic [T_W-1:0]          dt_r [3];
  logic [T_W-1:0]          t_r;
  logic [SW-1:0]           steps_r;
  logic [1:0]              ax_r;
  logic [SMP_W-1:0]        i_r, hits_r;
  logic [RATIO_W-1:0]      ratio_r;
  logic                    occ_r, ins_r, trunc_r, found_r;

  // key table
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [KEY_W-1:0] rd_data_r, key;
  logic [CNT_W-1:0] scan_idx_r;
  logic             rd_pend_r, scan_hit, scan_end, mem_we;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;

  // shared divider
  logic [DIV_N_W-1:0] dq_r, div_num;
  logic [DIV_D_W-1:0] drem_r, dden_r, div_den;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [DIV_D_W:0]   rem_sh, rem_diff;
  logic               rem_ge, div_go, div_done;
  logic [T_W-1:0]     q_sat;

  // per-axis helpers
  logic signed [DIR_W-1:0]  dir_ax;
  logic [DIV_D_W-1:0]       ad;
  logic signed [PROD_W-1:0] bnd_dist;
  logic [DIST_W-1:0]        dist_c;
  logic signed [POS_W+1:0]  pt_sum;
  logic signed [POS_W-1:0]  pt_sat;
  logic [1:0]               sel;
  logic [T_W:0]             tb_sum;
  logic [T_W-1:0]           tb_adv;
  logic [SMP_W-1:0]         hits_new;
  logic                     last_smp, t_done, cap_hit;

  assign limit = (maxv_r < CAP_LIM_C) ? maxv_r : CAP_LIM_C;
  assign key   = {cell_r[0][KEY_AXIS_BITS-1:0], cell_r[1][KEY_AXIS_BITS-1:0],
                  cell_r[2][KEY_AXIS_BITS-1:0]};

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign scan_hit = rd_pend_r && (rd_data_r == key);
  assign scan_end = (scan_idx_r == key_count_r);

  assign dir_ax = dir_r[ax_r];
  assign ad     = dir_ax[DIR_W-1] ? DIV_D_W'(-dir_ax) : DIV_D_W'(dir_ax);

  // distance to the first boundary, clamped to [0, 2^46]
  always_comb begin
    if (dir_ax[DIR_W-1]) begin
      bnd_dist = PROD_W'(pos_r[ax_r]) - prod_r;
    end else begin
      bnd_dist = prod_r - PROD_W'(pos_r[ax_r]);
    end
    if (bnd_dist < 0) begin
      dist_c = '0;
    end else if (bnd_dist > $signed({19'd0, DIST_CAP})) begin
      dist_c = DIST_CAP;
    end else begin
      dist_c = bnd_dist[DIST_W-1:0];
    end
  end

  // sample point: origin plus floor(t * dir / 2^16), saturated to 32 bits
  always_comb begin
    pt_sum = (POS_W+2)'(pos_r[ax_r]) + $signed(prod_r[POS_W+17:16]);
    if (pt_sum > $signed(34'h0_7FFF_FFFF)) begin
      pt_sat = 32'sh7FFF_FFFF;
    end else if (pt_sum < $signed(34'h3_8000_0000)) begin
      pt_sat = 32'sh8000_0000;
    end else begin
      pt_sat = pt_sum[POS_W-1:0];
    end
  end

  // nearest boundary crossing, ties go to the lower axis
  always_comb begin
    if (tb_r[0] <= tb_r[1] && tb_r[0] <= tb_r[2]) begin
      sel = 2'd0;
    end else if (tb_r[1] <= tb_r[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    tb_sum = {1'b0, tb_r[sel]} + {1'b0, dt_r[sel]};
    tb_adv = (tb_sum > {1'b0, T_INF}) ? T_INF : tb_sum[T_W-1:0];
  end

  assign hits_new = hits_r + SMP_W'(found_r);
  assign last_smp = ({1'b0, i_r} + 9'd1) == {1'b0, smp_r};
  assign t_done   = t_r >= T_W'(reach_r);
  assign cap_hit  = steps_r >= SW'(MAX_WALK_STEPS);

  assign rem_sh   = {drem_r, dq_r[DIV_N_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dden_r};
  assign rem_diff = rem_sh - {1'b0, dden_r};
  assign div_done = (dcnt_r == '0);
  assign q_sat    = (dq_r > DIV_N_W'(T_INF)) ? T_INF : dq_r[T_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_INSERT: state_nxt = (key_count_r >= limit) ? S_DONE : S_CELL_MUL;
            CMD_CLEAR:  state_nxt = S_DONE;
            CMD_WALK:   state_nxt = (key_count_r == '0) ? S_DONE : S_CELL_MUL;
            CMD_RATIO: begin
              state_nxt = (key_count_r == '0 || smp_r == '0) ? S_DONE : S_SMP_MUL;
            end
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_CELL_MUL: state_nxt = S_CELL_WB;
      S_CELL_WB: begin
        if (ax_r != AX_LAST) begin
          state_nxt = S_CELL_MUL;
        end else if (cmd_r == CMD_WALK) begin
          state_nxt = S_SET_MUL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SET_MUL: begin
        if (dir_ax != '0) begin
          state_nxt = S_SET_DIST;
        end else if (ax_r == AX_LAST) begin
          state_nxt = S_WALK;
        end
      end
      S_SET_DIST: state_nxt = S_SET_TB;
      S_SET_TB:   if (div_done) state_nxt = S_SET_DT;
      S_SET_DT: begin
        if (div_done) begin
          state_nxt = (ax_r == AX_LAST) ? S_WALK : S_SET_MUL;
        end
      end
      S_WALK:     state_nxt = (t_done || cap_hit) ? S_DONE : S_SCAN;
      S_SCAN:     if (scan_hit || scan_end) state_nxt = S_POST;
      S_POST: begin
        case (cmd_r)
          CMD_WALK:  state_nxt = found_r ? S_DONE : S_WALK;
          CMD_RATIO: state_nxt = last_smp ? S_RAT_DIV : S_SMP_MUL;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SMP_MUL:  state_nxt = S_SMP_DLD;
      S_SMP_DLD:  state_nxt = S_SMP_DIV;
      S_SMP_DIV:  if (div_done) state_nxt = S_PT_MUL;
      S_PT_MUL:   state_nxt = S_PT_ADD;
      S_PT_ADD:   state_nxt = (ax_r == AX_LAST) ? S_CELL_MUL : S_PT_MUL;
      S_RAT_DIV:  if (div_done) state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_num = '0;
    div_den = ad;
    mem_we  = 1'b0;
    case (state_r)
      S_CELL_MUL: begin
        mul_a = MUL_W'(pt_r[ax_r]);
        mul_b = $signed({2'b00, inv_r});
      end
      S_SET_MUL: begin
        mul_a = dir_ax[DIR_W-1] ? MUL_W'(cell_r[ax_r]) : MUL_W'(cell_r[ax_r]) + 33'sd1;
        mul_b = $signed({2'b00, vs_r});
      end
      S_SET_DIST: begin
        div_go  = 1'b1;
        div_num = {dist_c, 16'd0};
      end
      S_SET_TB: begin
        div_go  = div_done;
        div_num = DIV_N_W'({vs_r, 16'd0});
      end
      S_SMP_MUL: begin
        mul_a = $signed(MUL_W'({i_r, 1'b1}));
        mul_b = $signed({2'b00, reach_r});
      end
      S_SMP_DLD: begin
        div_go  = 1'b1;
        div_num = prod_r[DIV_N_W-1:0];
        div_den = DIV_D_W'({smp_r, 1'b0});
      end
      S_PT_MUL: begin
        mul_a = $signed({2'b00, t_r[REACH_W-1:0]});
        mul_b = MUL_W'(dir_ax);
      end
      S_POST: begin
        mem_we  = (cmd_r == CMD_INSERT) && !found_r;
        div_go  = (cmd_r == CMD_RATIO) && last_smp;
        div_num = DIV_N_W'({hits_new, 16'd0});
        div_den = DIV_D_W'(smp_r);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= '0;
      vs_r        <= VS_RST;
      inv_r       <= INV_RST;
      maxv_r      <= MAXV_RST;
      smp_r       <= SMP_RST;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start && cmd_t'(in_command) == CMD_CLEAR) begin
        key_count_r <= '0;
      end else if (mem_we) begin
        key_count_r <= key_count_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VOXEL_SIZE:     vs_r   <= cfg_data[VS_W-1:0];
          REG_INV_VOXEL_SIZE: inv_r  <= cfg_data[VS_W-1:0];
          REG_MAX_VOXELS:     maxv_r <= cfg_data[MAXV_W-1:0];
          REG_SAMPLE_STEPS:   smp_r  <= cfg_data[SMP_W-1:0];
          default: begin
          end
        endcase
      end
      if (div_go) begin
        dcnt_r <= DCNT_W'(DIV_N_W);
      end else if (!div_done) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
    end
  end

  // shared multiplier and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (div_go) begin
      dq_r   <= div_num;
      drem_r <= '0;
      dden_r <= div_den;
    end else if (!div_done) begin
      drem_r <= rem_ge ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      dq_r   <= {dq_r[DIV_N_W-2:0], rem_ge};
    end
  end

  // key table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[addr_t'(key_count_r)] <= key;
    end
    rd_data_r <= key_mem[addr_t'(scan_idx_r)];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_r    <= cmd_t'(in_command);
          pos_r[0] <= in_pos_x;
          pos_r[1] <= in_pos_y;
          pos_r[2] <= in_pos_z;
          pt_r[0]  <= in_pos_x;
          pt_r[1]  <= in_pos_y;
          pt_r[2]  <= in_pos_z;
          dir_r[0] <= in_dir_x;
          dir_r[1] <= in_dir_y;
          dir_r[2] <= in_dir_z;
          reach_r  <= in_reach;
          ax_r     <= '0;
          i_r      <= '0;
          hits_r   <= '0;
          ratio_r  <= '0;
          occ_r    <= 1'b0;
          ins_r    <= 1'b0;
          trunc_r  <= 1'b0;
        end
      end
      S_CELL_WB: begin
        cell_r[ax_r] <= prod_r[POS_W+31:32];
        ax_r         <= (ax_r == AX_LAST) ? 2'd0 : ax_r + 2'd1;
        t_r          <= '0;
        steps_r      <= '0;
        scan_idx_r   <= '0;
        rd_pend_r    <= 1'b0;
      end
      S_SET_MUL: begin
        if (dir_ax == '0) begin
          tb_r[ax_r] <= T_INF;
          dt_r[ax_r] <= T_INF;
          ax_r       <= (ax_r == AX_LAST) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_SET_TB: begin
        if (div_done) begin
          tb_r[ax_r] <= q_sat;
        end
      end
      S_SET_DT: begin
        if (div_done) begin
          dt_r[ax_r] <= q_sat;
          ax_r       <= (ax_r == AX_LAST) ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_WALK: begin
        scan_idx_r <= '0;
        rd_pend_r  <= 1'b0;
        if (!t_done && cap_hit) begin
          trunc_r <= 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_r <= 1'b1;
        end else if (scan_end) begin
          found_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
          rd_pend_r  <= 1'b1;
        end
      end
      S_POST: begin
        case (cmd_r)
          CMD_INSERT: ins_r <= !found_r;
          CMD_WALK: begin
            if (found_r) begin
              occ_r <= 1'b1;
            end else begin
              // step into the next voxel along the nearest crossing
              t_r         <= tb_r[sel];
              tb_r[sel]   <= tb_adv;
              cell_r[sel] <= dir_r[sel][DIR_W-1] ? cell_r[sel] - 32'sd1
                                                 : cell_r[sel] + 32'sd1;
              steps_r     <= steps_r + 1'b1;
            end
          end
          CMD_RATIO: begin
            hits_r <= hits_new;
            i_r    <= i_r + 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SMP_DIV: begin
        if (div_done) begin
          t_r <= T_W'(dq_r[REACH_W-1:0]);
        end
      end
      S_PT_ADD: begin
        pt_r[ax_r] <= pt_sat;
        ax_r       <= (ax_r == AX_LAST) ? 2'd0 : ax_r + 2'd1;
      end
      S_RAT_DIV: begin
        if (div_done) begin
          ratio_r <= dq_r[RATIO_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = (state_r == S_DONE);
  assign out_occluded     = occ_r;
  assign out_hit_samples  = hits_r;
  assign out_ratio        = ratio_r;
  assign out_inserted     = ins_r;
  assign out_full_res     = (key_count_r >= limit);
  assign out_stored_count = key_count_r;
  assign out_truncated    = trunc_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_insert_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |-> out_stored_count <= limit)
    else $error("insert went past the key limit");

  a_walk_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_occluded && out_truncated))
    else $error("walk reported both occluded and truncated");

endmodule

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking testbench for voxel_ray_occlusion_grid
// depends on vrog_pkg and the block's rtl; an internal predictor or directed values supply expected results
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vrog_pkg::*;

  localparam int       CAP        = 4096;
  localparam int       WALK_CAP   = 1024;
  localparam int       AXB        = 21;
  localparam longint   TINF       = longint'(1) << 48;
  localparam longint   DCAP       = longint'(1) << 46;
  localparam int       CYCLE_LIMIT = 30_000_000;

  typedef struct {
    cmd_t                  cmd;
    logic signed [31:0]    px, py, pz;
    logic signed [17:0]    dx, dy, dz;
    logic [30:0]           reach;
  } item_t;

  typedef struct {
    logic        occ;
    logic [7:0]  hits;
    logic [16:0] ratio;
    logic        ins;
    logic        full;
    logic [12:0] cnt;
    logic        trunc;
  } res_t;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_command;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [DIR_W-1:0] in_dir_x, in_dir_y, in_dir_z;
  logic [REACH_W-1:0] in_reach;
  logic out_valid, out_occluded, out_inserted, out_full_res, out_truncated;
  logic [SMP_W-1:0] out_hit_samples;
  logic [RATIO_W-1:0] out_ratio;
  logic [CNT_W-1:0] out_stored_count;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  voxel_ray_occlusion_grid u_top (.*);

  always #6 clk = ~clk;

  // shadow of the block's registers and key set
  longint     sh_vs, sh_inv, sh_maxv, sh_steps;
  logic [62:0] sh_keys [CAP];
  int         sh_count;

  res_t pending_q[$];
  int   fails;
  int   cycles;

  function automatic longint vox_cell(longint p);
    return (p * sh_inv) >>> 32;
  endfunction

  function automatic logic [62:0] pack_cell(longint cx, longint cy, longint cz);
    logic [AXB-1:0] x, y, z;
    x = cx[AXB-1:0];
    y = cy[AXB-1:0];
    z = cz[AXB-1:0];
    return {x, y, z};
  endfunction

  function automatic bit key_present(logic [62:0] k);
    for (int i = 0; i < sh_count && i < CAP; i++)
      if (sh_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int key_limit();
    return (sh_maxv < CAP) ? int'(sh_maxv) : CAP;
  endfunction

  function automatic longint cross_time(longint d_len, longint ad);
    longint q;
    if (d_len < 0) d_len = 0;
    if (d_len > DCAP) d_len = DCAP;
    q = (d_len << 16) / ad;
    return (q > TINF) ? TINF : q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // amanatides-woo stepping over the shadow key set
  function automatic void ray_walk(longint o[3], longint d[3], longint reach,
                                   output logic occ, output logic trunc);
    longint c[3], tb[3], dt[3], st[3], ad, t, s;
    int steps, a;
    occ = 0;
    trunc = 0;
    t = 0;
    steps = 0;
    for (a = 0; a < 3; a++) begin
      c[a] = vox_cell(o[a]);
      ad = (d[a] < 0) ? -d[a] : d[a];
      st[a] = (d[a] >= 0) ? 1 : -1;
      if (d[a] == 0) begin
        tb[a] = TINF;
        dt[a] = TINF;
      end else begin
        tb[a] = (d[a] > 0) ? cross_time((c[a] + 1) * sh_vs - o[a], ad)
                           : cross_time(o[a] - c[a] * sh_vs, ad);
        dt[a] = cross_time(sh_vs, ad);
      end
    end
    while (t < reach) begin
      if (steps >= WALK_CAP) begin
        trunc = 1;
        return;
      end
      if (key_present(pack_cell(c[0], c[1], c[2]))) begin
        occ = 1;
        return;
      end
      steps++;
      if (tb[0] <= tb[1] && tb[0] <= tb[2]) a = 0;
      else if (tb[1] <= tb[2]) a = 1;
      else a = 2;
      t = tb[a];
      s = tb[a] + dt[a];
      tb[a] = (s > TINF) ? TINF : s;
      c[a] += st[a];
    end
  endfunction

  function automatic longint count_sample_hits(longint o[3], longint d[3], longint reach);
    longint t, hits, c[3];
    hits = 0;
    for (longint i = 0; i < sh_steps; i++) begin
      t = ((2 * i + 1) * reach) / (2 * sh_steps);
      for (int a = 0; a < 3; a++)
        c[a] = vox_cell(clamp32(o[a] + ((t * d[a]) >>> 16)));
      if (key_present(pack_cell(c[0], c[1], c[2]))) hits++;
    end
    return hits;
  endfunction

  // advances the shadow state by one item and returns its result
  function automatic res_t grid_predict(item_t it);
    res_t r;
    longint o[3], d[3], hits;
    logic [62:0] k;
    r = '{default: '0};
    o[0] = it.px; o[1] = it.py; o[2] = it.pz;
    d[0] = it.dx; d[1] = it.dy; d[2] = it.dz;
    case (it.cmd)
      CMD_INSERT: begin
        if (sh_count < key_limit()) begin
          k = pack_cell(vox_cell(o[0]), vox_cell(o[1]), vox_cell(o[2]));
          if (!key_present(k)) begin
            sh_keys[sh_count] = k;
            sh_count++;
            r.ins = 1;
          end
        end
      end
      CMD_CLEAR: sh_count = 0;
      CMD_WALK: if (sh_count != 0) ray_walk(o, d, longint'(it.reach), r.occ, r.trunc);
      default: begin
        if (sh_count != 0 && sh_steps != 0) begin
          hits = count_sample_hits(o, d, longint'(it.reach));
          r.hits = hits[7:0];
          r.ratio = 17'((hits << 16) / sh_steps);
        end
      end
    endcase
    r.full = (sh_count >= key_limit());
    r.cnt = 13'(sh_count);
    return r;
  endfunction

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding");
        fails++;
      end else begin
        e = pending_q.pop_front();
        check_field("occluded", e.occ, out_occluded);
        check_field("hit_samples", e.hits, out_hit_samples);
        check_field("ratio", e.ratio, out_ratio);
        check_field("inserted", e.ins, out_inserted);
        check_field("full_res", e.full, out_full_res);
        check_field("stored_count", e.cnt, out_stored_count);
        check_field("truncated", e.trunc, out_truncated);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  bit gaps_on;

  task automatic send_item(item_t it, bit typed, res_t texp);
    int g, p;
    res_t r;
    g = 0;
    if (gaps_on) begin
      p = $urandom_range(0, 99);
      if (p >= 95) g = $urandom_range(10, 40);
      else if (p >= 70) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_command <= it.cmd;
    in_pos_x <= it.px;
    in_pos_y <= it.py;
    in_pos_z <= it.pz;
    in_dir_x <= it.dx;
    in_dir_y <= it.dy;
    in_dir_z <= it.dz;
    in_reach <= it.reach;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = grid_predict(it);
    pending_q.push_back(typed ? texp : r);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_index <= idx;
    cfg_data <= val[31:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VOXEL_SIZE:     sh_vs = val & 32'h7FFF_FFFF;
      REG_INV_VOXEL_SIZE: sh_inv = val & 32'h7FFF_FFFF;
      REG_MAX_VOXELS:     sh_maxv = val & 13'h1FFF;
      REG_SAMPLE_STEPS:   sh_steps = val & 8'hFF;
      default: ;
    endcase
  endtask

  function automatic item_t mk(cmd_t c, longint px, longint py, longint pz,
                               longint dx, longint dy, longint dz, longint reach);
    item_t it;
    it.cmd = c;
    it.px = px[31:0]; it.py = py[31:0]; it.pz = pz[31:0];
    it.dx = dx[17:0]; it.dy = dy[17:0]; it.dz = dz[17:0];
    it.reach = reach[30:0];
    return it;
  endfunction

  function automatic res_t rs(logic occ, logic ins, logic full, int cnt);
    res_t r;
    r = '{default: '0};
    r.occ = occ; r.ins = ins; r.full = full; r.cnt = 13'(cnt);
    return r;
  endfunction

  function automatic logic signed [17:0] rand_dir();
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  // most items sit near a cluster so walks and samples meet stored voxels
  function automatic item_t rand_item(longint base, longint span);
    item_t it;
    int p;
    p = $urandom_range(0, 99);
    if (sh_count > 40) it.cmd = CMD_CLEAR;
    else if (p < 40) it.cmd = CMD_INSERT;
    else if (p < 44) it.cmd = CMD_CLEAR;
    else if (p < 72) it.cmd = CMD_WALK;
    else it.cmd = CMD_RATIO;
    if ($urandom_range(0, 9) == 0) begin
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    end else begin
      it.px = 32'(base + $urandom_range(0, span));
      it.py = 32'(base + $urandom_range(0, span));
      it.pz = 32'(base - $urandom_range(0, span));
    end
    it.dx = rand_dir(); it.dy = rand_dir(); it.dz = rand_dir();
    p = $urandom_range(0, 99);
    if (p < 3) it.reach = $urandom;
    else if (p < 8) it.reach = '0;
    else it.reach = 31'($urandom_range(0, 2 * span));
    return it;
  endfunction

  task automatic random_phase(int n, longint base, longint span);
    res_t none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gaps_on = $urandom_range(0, 3) != 0;
      send_item(rand_item(base, span), 1'b0, none);
    end
    drain();
  endtask

  row_t rows [$];

  initial begin
    res_t none;
    none = '{default: '0};
    fails = 0;
    cycles = 0;
    gaps_on = 1'b1;
    sh_vs = VS_RST; sh_inv = INV_RST; sh_maxv = MAXV_RST; sh_steps = SMP_RST;
    sh_count = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_INSERT;
    in_pos_x <= '0; in_pos_y <= '0; in_pos_z <= '0;
    in_dir_x <= '0; in_dir_y <= '0; in_dir_z <= '0;
    in_reach <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_VOXEL_SIZE;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, default voxel of 0.1 m
    rows.push_back('{mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_RATIO, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 1, 0, 1)});
    rows.push_back('{mk(CMD_INSERT, 100, 200, 300, 0, 0, 0, 0), 1, rs(0, 0, 0, 1)});
    rows.push_back('{mk(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        65536, 65536, 65536, 31'h7FFF_FFFF), 0, none});
    rows.push_back('{mk(CMD_INSERT, -64'sd2147483648, -64'sd2147483648,
                        -64'sd2147483648, -65536, -65536, -65536, 0), 0, none});
    rows.push_back('{mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(1, 0, 0, 3)});
    rows.push_back('{mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 0), 1, rs(0, 0, 0, 3)});
    rows.push_back('{mk(CMD_WALK, 65536, 0, 0, 0, 0, 0, 1000), 0, none});
    rows.push_back('{mk(CMD_WALK, 65536, 3000, 3000, -65536, 0, 0, 131072), 0, none});
    rows.push_back('{mk(CMD_WALK, 20000, -30000, 9000, -46341, 46341, 0, 196608), 0, none});
    rows.push_back('{mk(CMD_WALK, -20000, -20000, -20000, 37837, 37837, 37837, 131072),
                     0, none});
    rows.push_back('{mk(CMD_RATIO, -65536, 1000, 1000, 65536, 0, 0, 131072), 0, none});
    rows.push_back('{mk(CMD_RATIO, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF), 0, none});
    rows.push_back('{mk(CMD_RATIO, 32'h7FFF_0000, 0, 0, 65536, -65536, 65536,
                        31'h7FFF_FFFF), 0, none});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_RATIO, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(0, 0, 0, 0)});
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].r);
    drain();

    // small key limit: full set, then limit lowered under the count
    write_reg(REG_MAX_VOXELS, 2);
    write_reg(3'd5, 32'hFFFF_FFFF);
    send_item(mk(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 1, 0, 1));
    send_item(mk(CMD_INSERT, 65536, 0, 0, 0, 0, 0, 0), 1, rs(0, 1, 1, 2));
    send_item(mk(CMD_INSERT, 131072, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 1, 2));
    drain();
    write_reg(REG_MAX_VOXELS, 1);
    write_reg(REG_SAMPLE_STEPS, 0);
    send_item(mk(CMD_RATIO, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(0, 0, 1, 2));
    send_item(mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 65536), 1, rs(1, 0, 1, 2));
    send_item(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0));
    drain();
    write_reg(REG_MAX_VOXELS, 0);
    send_item(mk(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 1, 0));
    drain();

    // tiny voxels so a long walk runs into the step cap
    write_reg(REG_MAX_VOXELS, 4096);
    write_reg(REG_VOXEL_SIZE, 1);
    write_reg(REG_INV_VOXEL_SIZE, 31'h7FFF_FFFF);
    write_reg(REG_SAMPLE_STEPS, 255);
    send_item(mk(CMD_INSERT, -65536, -65536, -65536, 0, 0, 0, 0), 1, rs(0, 1, 0, 1));
    send_item(mk(CMD_WALK, 0, 0, 0, 65536, 0, 0, 31'h7FFF_FFFF), 0, none);
    send_item(mk(CMD_WALK, 0, 0, 0, 30000, -40000, 50000, 31'h7FFF_FFFF), 0, none);
    send_item(mk(CMD_RATIO, -65536, -65536, -65536, 0, 0, 0, 655360), 0, none);
    drain();

    // random phases over several register settings
    write_reg(REG_VOXEL_SIZE, VS_RST);
    write_reg(REG_INV_VOXEL_SIZE, INV_RST);
    write_reg(REG_SAMPLE_STEPS, 8);
    random_phase(250, 0, 98304);

    write_reg(REG_VOXEL_SIZE, 65536);
    write_reg(REG_INV_VOXEL_SIZE, 65536);
    write_reg(REG_SAMPLE_STEPS, 1);
    write_reg(REG_MAX_VOXELS, 12);
    random_phase(200, -262144, 393216);

    write_reg(REG_VOXEL_SIZE, 16384);
    write_reg(REG_INV_VOXEL_SIZE, 262144);
    write_reg(REG_SAMPLE_STEPS, 24);
    write_reg(REG_MAX_VOXELS, 4096);
    random_phase(250, 1_000_000, 131072);

    write_reg(REG_VOXEL_SIZE, 31'h7FFF_FFFF);
    write_reg(REG_INV_VOXEL_SIZE, 1);
    write_reg(REG_SAMPLE_STEPS, 255);
    random_phase(40, 0, 1_000_000);

    write_reg(REG_VOXEL_SIZE, 32768);
    write_reg(REG_INV_VOXEL_SIZE, 131072);
    write_reg(REG_SAMPLE_STEPS, 4);
    random_phase(80, -500_000, 131072);

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
